// ----- src/bpa_pkg.sv -----
// Package for the buddy page allocator: request and status codes and the
// controller state type. It has no dependencies.
package bpa_pkg;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_RANK  = 2'd2;
    localparam logic [1:0] FUNC_COUNT = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    localparam int VALUE_W = 16;

    typedef enum logic [12:0] {
        S_INIT   = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_APOP   = 13'b0000000000100,
        S_ASPLIT = 13'b0000000001000,
        S_AFIN   = 13'b0000000010000,
        S_FCHK   = 13'b0000000100000,
        S_FLOOP  = 13'b0000001000000,
        S_FBCHK  = 13'b0000010000000,
        S_FWALK  = 13'b0000100000000,
        S_FLOSE  = 13'b0001000000000,
        S_FPUSH  = 13'b0010000000000,
        S_QWALK  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

endpackage

// ----- src/buddy_page_allocator.sv -----
// Top level of the buddy page allocator: page table memory, free list heads
// and counts, and the request sequencer. Depends on bpa_pkg.
//
//   Channel   Direction  Handshake            Contents
//   config    in         i_cfg_we             i_cfg_data (pool size in pages)
//   request   in         i_valid / o_stall    i_func, i_rank, i_page_index
//   result    out        o_valid / i_stall    o_status, o_page_index_out, o_value
//
// A count query, and any request rejected at once, goes straight to its
// result. An allocation pops the head of the smallest nonempty fitting
// rank and splits it down to the requested rank. A free checks that the
// page is an allocated block start, then reads each buddy in turn; a free
// buddy is unlinked from its list, walking the list if need be, and merged,
// and the final block is pushed. A rank query steps back page by page to
// the block start. These steps are set by the one read port of the page
// table, whose read data is registered.
// Reset and every accepted pool size write start a rebuild that sweeps the
// whole page table, with o_stall held high.
// A finished result waits in the output register while the next request is
// already accepted; only a second finished result waits for i_stall.
module buddy_page_allocator #(
    parameter int MAX_PAGES_LOG2 = 15,
    parameter int TOP_RANK       = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_rank,
    input  logic [14:0] i_page_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [14:0] o_page_index_out,
    output logic [15:0] o_value
);
    import bpa_pkg::*;

    localparam int L        = MAX_PAGES_LOG2;
    localparam int P        = 2 ** L;
    localparam int PA       = L + 1;
    localparam int RW       = $clog2(TOP_RANK + 1);
    localparam int CW       = (PA > 16) ? PA : 16;
    localparam int POOL_RST = (32768 < P) ? 32768 : P;
    // Page value that marks an empty list or the end of a list.
    localparam logic [PA-1:0] NIL = {1'b1, {L{1'b0}}};

    typedef struct packed {
        logic          start;
        logic [RW-1:0] rank;
        logic          taken;
        logic [PA-1:0] next;
    } t_entry;

    // Page table: one entry per page, read data registered.
    t_entry        r_mem [P];
    t_entry        r_rdata;
    logic [L-1:0]  rd_addr;
    logic          wr_en;
    logic [L-1:0]  wr_addr;
    t_entry        wr_data;

    // Free list heads and counts, one per rank.
    logic [PA-1:0] r_head [TOP_RANK+1];
    logic [PA-1:0] r_cnt  [TOP_RANK+1];
    logic [RW-1:0] ridx;
    logic [PA-1:0] head_rd, cnt_rd, head_wd;
    logic          head_we, cnt_inc, cnt_dec, head_clr;

    t_state        r_state, n_state;
    logic [PA-1:0] r_pool, n_pool;
    logic [L-1:0]  r_bpg, n_bpg;
    logic [PA-1:0] r_bnext, n_bnext;
    logic [PA-1:0] r_bleft, n_bleft;
    logic [L-1:0]  r_pg, n_pg;
    logic [L-1:0]  r_bud, n_bud;
    logic [L-1:0]  r_cur, n_cur;
    logic [RW-1:0] r_r, n_r;
    logic [RW-1:0] r_k, n_k;
    logic [PA-1:0] r_pgnext, n_pgnext;
    logic [PA-1:0] r_budnext, n_budnext;
    logic          r_split, n_split;
    logic          r_ostart, n_ostart;
    logic [RW-1:0] r_orank, n_orank;
    logic [1:0]    r_status, n_status;
    logic [14:0]   r_pout, n_pout;
    logic [15:0]   r_val, n_val;
    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_ostatus, n_ostatus;
    logic [14:0]   r_opout, n_opout;
    logic [15:0]   r_oval, n_oval;

    // Rebuild: largest block rank that fits in the pages still left.
    logic [RW-1:0] b_rank;
    logic [PA-1:0] b_size;
    // Allocation: smallest nonempty rank at or above the request.
    logic [RW-1:0] found;
    logic          found_any;
    logic          k_bad;
    logic [CW-1:0] page_ext;
    logic          page_ok;
    logic [CW-1:0] cfg_ext;
    logic          cfg_ok;
    logic [RW-1:0] sh;
    logic [PA-1:0] split_bud;
    logic [RW-1:0] r_m1;
    logic [L-1:0]  merge_bud;
    logic          merge_ok;

    assign head_rd = r_head[ridx];
    assign cnt_rd  = r_cnt[ridx];

    always_comb begin
        int m;
        m = 0;
        for (int i = 0; i <= L; i++) begin
            if (r_bleft[i]) begin
                m = i;
            end
        end
        b_rank = (m + 1 > TOP_RANK) ? RW'(TOP_RANK) : RW'(m + 1);
        b_size = PA'(1) << (b_rank - RW'(1));
    end

    always_comb begin
        found     = '0;
        found_any = 1'b0;
        for (int j = TOP_RANK; j >= 1; j--) begin
            if (j >= int'(i_rank) && !r_head[j][L]) begin
                found     = RW'(j);
                found_any = 1'b1;
            end
        end
    end

    assign k_bad    = (i_rank == 5'd0) || (int'(i_rank) > TOP_RANK);
    assign page_ext = CW'(i_page_index);
    assign page_ok  = page_ext < CW'(r_pool);
    assign cfg_ext  = CW'(i_cfg_data);
    assign cfg_ok   = (i_cfg_data != 16'd0) && (cfg_ext <= CW'(P));

    assign sh        = r_r - RW'(2);
    assign split_bud = {1'b0, r_pg} + (PA'(1) << sh);
    assign r_m1      = r_r - RW'(1);
    assign merge_bud = r_pg ^ (L'(1) << r_m1);
    assign merge_ok  = (r_r != '0) && (int'(r_r) < TOP_RANK) && (int'(r_m1) < L)
                       && ({1'b0, merge_bud} < r_pool);

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_page_index_out = r_opout;
    assign o_value          = r_oval;

    always_comb begin
        n_state   = r_state;
        n_pool    = r_pool;
        n_bpg     = r_bpg;
        n_bnext   = r_bnext;
        n_bleft   = r_bleft;
        n_pg      = r_pg;
        n_bud     = r_bud;
        n_cur     = r_cur;
        n_r       = r_r;
        n_k       = r_k;
        n_pgnext  = r_pgnext;
        n_budnext = r_budnext;
        n_split   = r_split;
        n_ostart  = r_ostart;
        n_orank   = r_orank;
        n_status  = r_status;
        n_pout    = r_pout;
        n_val     = r_val;
        n_ovalid  = r_ovalid && i_stall;
        n_ostatus = r_ostatus;
        n_opout   = r_opout;
        n_oval    = r_oval;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;
        ridx      = '0;
        head_we   = 1'b0;
        head_wd   = '0;
        cnt_inc   = 1'b0;
        cnt_dec   = 1'b0;
        head_clr  = 1'b0;

        case (r_state)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = r_bpg;
                if (r_bleft != '0 && {1'b0, r_bpg} == r_bnext) begin
                    ridx    = b_rank;
                    wr_data = '{start: 1'b1, rank: b_rank, taken: 1'b0, next: head_rd};
                    head_we = 1'b1;
                    head_wd = {1'b0, r_bpg};
                    cnt_inc = 1'b1;
                    n_bnext = r_bnext + b_size;
                    n_bleft = r_bleft - b_size;
                end else begin
                    wr_data = '{start: 1'b0, rank: '0, taken: 1'b0, next: NIL};
                end
                n_bpg = r_bpg + L'(1);
                if (&r_bpg) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_k      = RW'(i_rank);
                    n_status = ST_OK;
                    n_pout   = '0;
                    n_val    = '0;
                    n_split  = 1'b0;
                    case (i_func)
                        FUNC_ALLOC: begin
                            if (k_bad) begin
                                n_status = ST_INVALID;
                                n_state  = S_DONE;
                            end else if (!found_any) begin
                                n_status = ST_NOSPACE;
                                n_state  = S_DONE;
                            end else begin
                                ridx    = found;
                                rd_addr = head_rd[L-1:0];
                                n_pg    = head_rd[L-1:0];
                                n_r     = found;
                                n_split = (found != RW'(i_rank));
                                n_state = S_APOP;
                            end
                        end
                        FUNC_FREE: begin
                            if (!page_ok) begin
                                n_status = ST_INVALID;
                                n_state  = S_DONE;
                            end else begin
                                rd_addr = page_ext[L-1:0];
                                n_pg    = page_ext[L-1:0];
                                n_state = S_FCHK;
                            end
                        end
                        FUNC_RANK: begin
                            if (!page_ok) begin
                                n_status = ST_INVALID;
                                n_state  = S_DONE;
                            end else begin
                                rd_addr = page_ext[L-1:0];
                                n_pg    = page_ext[L-1:0];
                                n_state = S_QWALK;
                            end
                        end
                        default: begin
                            if (k_bad) begin
                                n_status = ST_INVALID;
                            end else begin
                                ridx  = RW'(i_rank);
                                n_val = VALUE_W'(cnt_rd);
                            end
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_APOP: begin
                // The popped block's successor becomes the list head.
                ridx     = r_r;
                head_we  = 1'b1;
                head_wd  = r_rdata.next;
                cnt_dec  = 1'b1;
                n_ostart = r_rdata.start;
                n_orank  = r_rdata.rank;
                n_state  = r_split ? S_ASPLIT : S_AFIN;
            end
            S_ASPLIT: begin
                // Halve the block; the upper half goes on the next lower rank.
                ridx = r_m1;
                if (int'(sh) < L && !split_bud[L]) begin
                    wr_en   = 1'b1;
                    wr_addr = split_bud[L-1:0];
                    wr_data = '{start: 1'b1, rank: r_m1, taken: 1'b0, next: head_rd};
                    head_we = 1'b1;
                    head_wd = split_bud;
                    cnt_inc = 1'b1;
                end
                n_r = r_m1;
                if (r_m1 == r_k) begin
                    n_state = S_AFIN;
                end
            end
            S_AFIN: begin
                wr_en   = 1'b1;
                wr_addr = r_pg;
                wr_data = '{start: r_split ? 1'b1 : r_ostart,
                            rank:  r_split ? r_k : r_orank,
                            taken: 1'b1, next: NIL};
                n_pout  = 15'(r_pg);
                n_state = S_DONE;
            end
            S_FCHK: begin
                if (!r_rdata.start || !r_rdata.taken) begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end else begin
                    n_r      = r_rdata.rank;
                    n_pgnext = r_rdata.next;
                    n_state  = S_FLOOP;
                end
            end
            S_FLOOP: begin
                if (merge_ok) begin
                    rd_addr = merge_bud;
                    n_bud   = merge_bud;
                    n_state = S_FBCHK;
                end else begin
                    n_state = S_FPUSH;
                end
            end
            S_FBCHK: begin
                ridx = r_r;
                if (!r_rdata.start || r_rdata.taken || r_rdata.rank != r_r) begin
                    n_state = S_FPUSH;
                end else begin
                    n_budnext = r_rdata.next;
                    if (head_rd == {1'b0, r_bud}) begin
                        head_we = 1'b1;
                        head_wd = r_rdata.next;
                        cnt_dec = 1'b1;
                        n_state = S_FLOSE;
                    end else if (head_rd[L]) begin
                        n_state = S_FLOSE;
                    end else begin
                        rd_addr = head_rd[L-1:0];
                        n_cur   = head_rd[L-1:0];
                        n_state = S_FWALK;
                    end
                end
            end
            S_FWALK: begin
                // Step down the list until the entry that points at the buddy, or its end.
                ridx = r_r;
                if (r_rdata.next == {1'b0, r_bud}) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cur;
                    wr_data = '{start: r_rdata.start, rank: r_rdata.rank,
                                taken: r_rdata.taken, next: r_budnext};
                    cnt_dec = 1'b1;
                    n_state = S_FLOSE;
                end else if (r_rdata.next[L]) begin
                    n_state = S_FLOSE;
                end else begin
                    rd_addr = r_rdata.next[L-1:0];
                    n_cur   = r_rdata.next[L-1:0];
                end
            end
            S_FLOSE: begin
                // The higher of the pair stops being a block start.
                wr_en = 1'b1;
                if (r_bud < r_pg) begin
                    wr_addr  = r_pg;
                    wr_data  = '{start: 1'b0, rank: '0, taken: 1'b0, next: r_pgnext};
                    n_pg     = r_bud;
                    n_pgnext = NIL;
                end else begin
                    wr_addr = r_bud;
                    wr_data = '{start: 1'b0, rank: '0, taken: 1'b0, next: NIL};
                end
                n_r     = r_r + RW'(1);
                n_state = S_FLOOP;
            end
            S_FPUSH: begin
                ridx    = r_r;
                wr_en   = 1'b1;
                wr_addr = r_pg;
                wr_data = '{start: 1'b1, rank: r_r, taken: 1'b0, next: head_rd};
                head_we = 1'b1;
                head_wd = {1'b0, r_pg};
                cnt_inc = 1'b1;
                n_state = S_DONE;
            end
            S_QWALK: begin
                // One page per cycle back toward the start of its block.
                if (r_rdata.start) begin
                    n_val   = VALUE_W'(r_rdata.rank);
                    n_state = S_DONE;
                end else if (r_pg == '0) begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end else begin
                    n_pg    = r_pg - L'(1);
                    rd_addr = r_pg - L'(1);
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_opout   = r_pout;
                    n_oval    = r_val;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A valid pool size write restarts the rebuild sweep.
        if (i_cfg_we && cfg_ok) begin
            n_pool   = cfg_ext[PA-1:0];
            n_bleft  = cfg_ext[PA-1:0];
            n_bpg    = '0;
            n_bnext  = '0;
            n_state  = S_INIT;
            head_clr = 1'b1;
            wr_en    = 1'b0;
            head_we  = 1'b0;
            cnt_inc  = 1'b0;
            cnt_dec  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || head_clr) begin
            for (int j = 0; j <= TOP_RANK; j++) begin
                r_head[j] <= NIL;
                r_cnt[j]  <= '0;
            end
        end else begin
            if (head_we) begin
                r_head[ridx] <= head_wd;
            end
            if (cnt_inc) begin
                r_cnt[ridx] <= cnt_rd + PA'(1);
            end else if (cnt_dec) begin
                r_cnt[ridx] <= cnt_rd - PA'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_pool   <= PA'(POOL_RST);
            r_bleft  <= PA'(POOL_RST);
            r_bpg    <= '0;
            r_bnext  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pool   <= n_pool;
            r_bleft  <= n_bleft;
            r_bpg    <= n_bpg;
            r_bnext  <= n_bnext;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pg      <= n_pg;
        r_bud     <= n_bud;
        r_cur     <= n_cur;
        r_r       <= n_r;
        r_k       <= n_k;
        r_pgnext  <= n_pgnext;
        r_budnext <= n_budnext;
        r_split   <= n_split;
        r_ostart  <= n_ostart;
        r_orank   <= n_orank;
        r_status  <= n_status;
        r_pout    <= n_pout;
        r_val     <= n_val;
        r_ostatus <= n_ostatus;
        r_opout   <= n_opout;
        r_oval    <= n_oval;
    end

endmodule
